// ----- rtl/core/gddm_pkg.sv -----
// Package for the grid diffusion and decay map: payload structs, command codes,
// register indexes and the fixed sizes of the cell store.
// No dependencies; every other file of the block but gddm_ram imports it.
package gddm_pkg;

   // Grid store: the column field addresses the low bits of a cell's word, so
   // MAX_WIDTH is a power of two that matches the column field width.
   localparam int COORD_W     = 6;
   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int CELLS       = MAX_WIDTH * MAX_HEIGHT;
   localparam int CELL_ADDR_W = $clog2(CELLS);
   localparam int CELL_W      = 32;
   localparam int GRID_DIM_W  = 7;
   localparam int DECAY_W     = 16;

   // Stencil arithmetic: 8 terms of 32 bits need 35 bits, the product with an
   // unsigned 16-bit factor 52 bits; the average and the Q0.16 scale fold
   // into one arithmetic shift.
   localparam int SUM_W       = CELL_W + 3;
   localparam int PROD_W      = SUM_W + DECAY_W + 1;
   localparam int DECAY_SHIFT = 19;

   localparam logic signed [CELL_W-1:0] CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};
   localparam logic signed [CELL_W-1:0] CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};

   // Register file reset values.
   localparam logic [GRID_DIM_W-1:0] GRID_WIDTH_RST  = 7'd64;
   localparam logic [GRID_DIM_W-1:0] GRID_HEIGHT_RST = 7'd64;
   localparam logic [DECAY_W-1:0]    DECAY_RST       = 16'd45875;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_GET     = 3'd0,
      CMD_SET     = 3'd1,
      CMD_ADD     = 3'd2,
      CMD_CLEAR   = 3'd3,
      CMD_DIFFUSE = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      REG_GRID_WIDTH   = 2'd0,
      REG_GRID_HEIGHT  = 2'd1,
      REG_DECAY_FACTOR = 2'd2
   } reg_idx_type;

   typedef struct packed {
      logic [2:0]               cmd;
      logic [COORD_W-1:0]       cell_x;
      logic [COORD_W-1:0]       cell_y;
      logic signed [CELL_W-1:0] cell_value;
   } req_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] read_value;
      logic                     out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [GRID_DIM_W-1:0] grid_width;
      logic [GRID_DIM_W-1:0] grid_height;
      logic [DECAY_W-1:0]    decay_factor;
   } cfg_type;

   // One port of a cell buffer as driven by the sequencer.
   typedef struct packed {
      logic                   we;
      logic [CELL_ADDR_W-1:0] addr;
      logic [CELL_W-1:0]      wdata;
   } ram_req_type;

endpackage

// ----- rtl/core/grid_diffusion_decay_map.sv -----
// Top level of the grid diffusion and decay map: register file, sequencer and
// the two cell buffers. Depends on gddm_pkg, gddm_regs, gddm_engine, gddm_ram.
//
// A 64 by 64 grid of signed Q16.16 cells is held in two single-port RAMs, one
// of them current. Items are taken one at a time: after reset a clearing pass
// over all 4096 cells zeroes both buffers before the first request beat is
// taken. Get and add pass through an access state, as each needs one
// registered RAM read; set writes at acceptance and goes straight to the
// response state. Clear sweeps both buffers. Diffuse visits the interior cells
// one at a time, paced by the single read port: five reads, one per cycle,
// feeding the shared adder, then the shared multiplier and the write. A result
// beat waits in an output register, so the next request is accepted while it
// is still pending.
module grid_diffusion_decay_map
   import gddm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type           cfg;
   ram_req_type       ram0_req;
   ram_req_type       ram1_req;
   logic [CELL_W-1:0] ram0_rdata;
   logic [CELL_W-1:0] ram1_rdata;

   // Configuration registers.
   gddm_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer with the shared arithmetic.
   gddm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .ram0_req    (ram0_req),
      .ram1_req    (ram1_req),
      .ram0_rdata  (ram0_rdata),
      .ram1_rdata  (ram1_rdata)
   );

   // Cell buffers zero and one.
   gddm_ram #(
      .DEPTH (CELLS),
      .WIDTH (CELL_W)
   ) u_ram0 (
      .clock (clock),
      .we    (ram0_req.we),
      .addr  (ram0_req.addr),
      .wdata (ram0_req.wdata),
      .rdata (ram0_rdata)
   );

   gddm_ram #(
      .DEPTH (CELLS),
      .WIDTH (CELL_W)
   ) u_ram1 (
      .clock (clock),
      .we    (ram1_req.we),
      .addr  (ram1_req.addr),
      .wdata (ram1_req.wdata),
      .rdata (ram1_rdata)
   );

`ifndef NO_ASSERTIONS
   // While waiting for a request, a buffer is written only by an accepted set.
   a_idle_write_is_set: assert property (@(posedge clock) disable iff (reset)
      (ram0_req.we || ram1_req.we) && req_ready
      |-> req_valid && (req_payload.cmd == CMD_SET))
      else $error("buffer written while idle without a set beat");

   // Items are worked on one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in the cycle after an acceptance");

   // An out-of-range access never returns cell data.
   a_oor_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_of_range |-> rsp_payload.read_value == '0)
      else $error("out-of-range result carries a non-zero value");
`endif

endmodule

// ----- rtl/core/gddm_ram.sv -----
// Generic single-port RAM with a registered read, read-before-write.
// No dependencies; used for each of the two cell buffers.
module gddm_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access a cycle; the read returns the old word on a write.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/gddm_regs.sv -----
// Configuration register file behind the APB-style port: grid size and decay.
// Depends on gddm_pkg.
module gddm_regs
   import gddm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   // Register writes in the access phase; addresses beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width   <= GRID_WIDTH_RST;
         cfg_ff.grid_height  <= GRID_HEIGHT_RST;
         cfg_ff.decay_factor <= DECAY_RST;
      end else if (wr_en) begin
         unique case (idx)
            REG_GRID_WIDTH:   cfg_ff.grid_width   <= pwdata[GRID_DIM_W-1:0];
            REG_GRID_HEIGHT:  cfg_ff.grid_height  <= pwdata[GRID_DIM_W-1:0];
            REG_DECAY_FACTOR: cfg_ff.decay_factor <= pwdata[DECAY_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      unique case (idx)
         REG_GRID_WIDTH:   prdata = CSR_DATA_W'(cfg_ff.grid_width);
         REG_GRID_HEIGHT:  prdata = CSR_DATA_W'(cfg_ff.grid_height);
         REG_DECAY_FACTOR: prdata = CSR_DATA_W'(cfg_ff.decay_factor);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/gddm_engine.sv -----
// Command sequencer with the shared adder and multiplier: cell accesses,
// buffer clearing sweeps and the five-point diffusion walk.
// Depends on gddm_pkg; drives the two buffer RAMs through ram_req_type ports.
module gddm_engine
   import gddm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload,
   output ram_req_type       ram0_req,
   output ram_req_type       ram1_req,
   input  logic [CELL_W-1:0] ram0_rdata,
   input  logic [CELL_W-1:0] ram1_rdata
);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ACCESS,
      ST_CLEAR,
      ST_DIF_RD,
      ST_DIF_MUL,
      ST_DIF_WR,
      ST_RESP
   } state_type;

   // Read taps of one stencil: the centre first, then the four neighbours.
   localparam logic [2:0] TAP_CENTRE = 3'd0;
   localparam logic [2:0] TAP_NORTH  = 3'd1;
   localparam logic [2:0] TAP_SOUTH  = 3'd2;
   localparam logic [2:0] TAP_WEST   = 3'd3;
   localparam logic [2:0] TAP_EAST   = 3'd4;
   localparam logic [2:0] TAP_LAST   = 3'd5;

   state_type                state_ff;
   logic [2:0]               cmd_ff;
   logic [COORD_W-1:0]       x_ff;
   logic [COORD_W-1:0]       y_ff;
   logic signed [CELL_W-1:0] val_ff;
   logic signed [CELL_W-1:0] res_ff;
   logic                     oor_ff;
   logic [2:0]               tap_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [CELL_ADDR_W-1:0]   sweep_ff;
   logic                     cur_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic [GRID_DIM_W-1:0]    w_eff;
   logic [GRID_DIM_W-1:0]    h_eff;
   logic                     in_rng;
   logic                     x_more;
   logic                     y_more;
   logic signed [CELL_W-1:0] rd_cur;
   logic [CELL_ADDR_W-1:0]   tap_addr;
   logic [CELL_ADDR_W-1:0]   mem_addr;
   logic [CELL_W-1:0]        mem_wdata;
   logic                     clr_we;
   logic                     cur_we;
   logic                     oth_we;
   logic signed [SUM_W-1:0]  add_a;
   logic signed [SUM_W-1:0]  add_b;
   logic signed [SUM_W-1:0]  sum;
   logic                     sum_ovf;
   logic signed [CELL_W-1:0] sum_sat;
   logic signed [PROD_W-1:0] mul_res;

   // Grid size in use, limited to the store.
   assign w_eff = (cfg.grid_width > GRID_DIM_W'(MAX_WIDTH)) ?
                  GRID_DIM_W'(MAX_WIDTH) : cfg.grid_width;
   assign h_eff = (cfg.grid_height > GRID_DIM_W'(MAX_HEIGHT)) ?
                  GRID_DIM_W'(MAX_HEIGHT) : cfg.grid_height;

   assign in_rng = (GRID_DIM_W'(req_payload.cell_x) < w_eff) &&
                   (GRID_DIM_W'(req_payload.cell_y) < h_eff);

   // Whether the walk has another interior column or row after this one.
   assign x_more = (GRID_DIM_W'(x_ff) + GRID_DIM_W'(2)) < w_eff;
   assign y_more = (GRID_DIM_W'(y_ff) + GRID_DIM_W'(2)) < h_eff;

   assign rd_cur = cur_ff ? ram1_rdata : ram0_rdata;

   // Address of the stencil tap being read this cycle.
   always_comb begin
      unique case (tap_ff)
         TAP_NORTH: tap_addr = {y_ff - COORD_W'(1), x_ff};
         TAP_SOUTH: tap_addr = {y_ff + COORD_W'(1), x_ff};
         TAP_WEST:  tap_addr = {y_ff, x_ff - COORD_W'(1)};
         TAP_EAST:  tap_addr = {y_ff, x_ff + COORD_W'(1)};
         default:   tap_addr = {y_ff, x_ff};
      endcase
   end

   // Shared adder: stencil accumulation, or the saturating add of a cell.
   always_comb begin
      if (state_ff == ST_DIF_RD) begin
         add_a = (tap_ff == TAP_NORTH) ? '0 : acc_ff;
         add_b = (tap_ff == TAP_NORTH) ? (SUM_W'(rd_cur) <<< 2) : SUM_W'(rd_cur);
      end else begin
         add_a = SUM_W'(rd_cur);
         add_b = SUM_W'(val_ff);
      end
   end

   assign sum     = add_a + add_b;
   assign sum_ovf = sum[SUM_W-1:CELL_W-1] != {(SUM_W-CELL_W+1){sum[SUM_W-1]}};
   assign sum_sat = sum_ovf ? (sum[SUM_W-1] ? CELL_MIN : CELL_MAX) : sum[CELL_W-1:0];

   // Shared multiplier: the stencil sum times the unsigned decay factor.
   assign mul_res = $signed(acc_ff) * $signed({1'b0, cfg.decay_factor});

   // Buffer port control: one address for both RAMs, enables split by buffer.
   always_comb begin
      mem_addr  = {y_ff, x_ff};
      mem_wdata = '0;
      clr_we    = 1'b0;
      cur_we    = 1'b0;
      oth_we    = 1'b0;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_addr = sweep_ff;
            clr_we   = 1'b1;
         end
         ST_IDLE: begin
            mem_addr  = {req_payload.cell_y, req_payload.cell_x};
            mem_wdata = req_payload.cell_value;
            cur_we    = req_valid && in_rng && (req_payload.cmd == CMD_SET);
         end
         ST_ACCESS: begin
            mem_wdata = sum_sat;
            cur_we    = (cmd_ff == CMD_ADD);
         end
         ST_DIF_RD: begin
            mem_addr = tap_addr;
         end
         ST_DIF_WR: begin
            mem_wdata = prod_ff[DECAY_SHIFT +: CELL_W];
            oth_we    = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      ram0_req.addr  = mem_addr;
      ram0_req.wdata = mem_wdata;
      ram0_req.we    = clr_we || (cur_ff ? oth_we : cur_we);
      ram1_req.addr  = mem_addr;
      ram1_req.wdata = mem_wdata;
      ram1_req.we    = clr_we || (cur_ff ? cur_we : oth_we);
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         cur_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The result register fills from the response state and drains on a taken beat.
         if ((state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               sweep_ff <= sweep_ff + CELL_ADDR_W'(1);
               if (&sweep_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_payload.cmd;
                  x_ff   <= req_payload.cell_x;
                  y_ff   <= req_payload.cell_y;
                  val_ff <= req_payload.cell_value;
                  res_ff <= '0;
                  oor_ff <= 1'b0;
                  unique case (req_payload.cmd)
                     CMD_GET, CMD_SET, CMD_ADD: begin
                        if (!in_rng) begin
                           oor_ff   <= 1'b1;
                           state_ff <= ST_RESP;
                        end else if (req_payload.cmd == CMD_SET) begin
                           state_ff <= ST_RESP;
                        end else begin
                           state_ff <= ST_ACCESS;
                        end
                     end
                     CMD_CLEAR: begin
                        sweep_ff <= '0;
                        state_ff <= ST_CLEAR;
                     end
                     CMD_DIFFUSE: begin
                        if ((w_eff >= GRID_DIM_W'(3)) && (h_eff >= GRID_DIM_W'(3))) begin
                           x_ff     <= COORD_W'(1);
                           y_ff     <= COORD_W'(1);
                           tap_ff   <= TAP_CENTRE;
                           state_ff <= ST_DIF_RD;
                        end else begin
                           cur_ff   <= ~cur_ff;
                           state_ff <= ST_RESP;
                        end
                     end
                     default: state_ff <= ST_RESP;
                  endcase
               end
            end
            ST_ACCESS: begin
               if (cmd_ff == CMD_GET) begin
                  res_ff <= rd_cur;
               end
               state_ff <= ST_RESP;
            end
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + CELL_ADDR_W'(1);
               if (&sweep_ff) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_DIF_RD: begin
               // Read data arrives in the cycle after its address.
               tap_ff <= tap_ff + 3'd1;
               if (tap_ff != TAP_CENTRE) begin
                  acc_ff <= sum;
               end
               if (tap_ff == TAP_LAST) begin
                  state_ff <= ST_DIF_MUL;
               end
            end
            ST_DIF_MUL: begin
               prod_ff  <= mul_res;
               state_ff <= ST_DIF_WR;
            end
            ST_DIF_WR: begin
               tap_ff <= TAP_CENTRE;
               if (x_more) begin
                  x_ff     <= x_ff + COORD_W'(1);
                  state_ff <= ST_DIF_RD;
               end else if (y_more) begin
                  x_ff     <= COORD_W'(1);
                  y_ff     <= y_ff + COORD_W'(1);
                  state_ff <= ST_DIF_RD;
               end else begin
                  cur_ff   <= ~cur_ff;
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.read_value   <= res_ff;
                  rsp_ff.out_of_range <= oor_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
